>>> hdl/mmu_pkg.sv
`default_nettype none

package mmu_pkg;

	// Default largest matrix side
	localparam int MAX_DIM_DEF = 8;

	// Field widths
	localparam int OP_W      = 2;
	localparam int ROW_W     = 3;
	localparam int VAL_W     = 16;
	localparam int PROD_W    = 2 * VAL_W;
	localparam int OUT_W     = 40;
	localparam int CFG_W     = 4;
	localparam int REG_IDX_W = 3;

	// Opcodes of an input item
	localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
	localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_ROWS_A   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COLS_A   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ROWS_B   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_COLS_B   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ROWS_OUT = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_COLS_OUT = 3'd5;

	// Queue sizes (depths are powers of two so pointers wrap on their own)
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
	localparam int RESQ_DEPTH = 4;
	localparam int RESQ_PW    = $clog2(RESQ_DEPTH);
	localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_LOAD_A,
		CMD_LOAD_B,
		CMD_COMPUTE
	} cmd_kind_t;

	// Command held between front and back
	typedef struct packed {
		cmd_kind_t        kind;
		logic [ROW_W-1:0] row;
		logic [ROW_W-1:0] col;
		logic [VAL_W-1:0] value;
	} cmd_t;

	// Dimension registers
	typedef struct packed {
		logic [CFG_W-1:0] rows_a;
		logic [CFG_W-1:0] cols_a;
		logic [CFG_W-1:0] rows_b;
		logic [CFG_W-1:0] cols_b;
		logic [CFG_W-1:0] rows_out;
		logic [CFG_W-1:0] cols_out;
	} dims_t;

	// Control that travels with one multiply through the pipeline
	typedef struct packed {
		logic             err;
		logic             first;
		logic             fin;
		logic             last;
		logic [ROW_W-1:0] row;
		logic [ROW_W-1:0] col;
	} tag_t;

	// One result item
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [ROW_W-1:0] col;
		logic [OUT_W-1:0] value;
		logic             dim_error;
		logic             last;
	} result_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	function automatic logic dim_ok(input logic [CFG_W-1:0] d, input int max_dim);
		return (d != '0) && (int'(d) <= max_dim);
	endfunction

	function automatic logic dims_valid(input dims_t d, input int max_dim);
		return dim_ok(d.rows_a, max_dim) && dim_ok(d.cols_a, max_dim) &&
			dim_ok(d.rows_b, max_dim) && dim_ok(d.cols_b, max_dim) &&
			dim_ok(d.rows_out, max_dim) && dim_ok(d.cols_out, max_dim) &&
			(d.cols_a == d.rows_b) && (d.rows_a == d.rows_out) &&
			(d.cols_b == d.cols_out);
	endfunction

endpackage

`default_nettype wire

>>> hdl/mmu_front.sv
`default_nettype none

module mmu_front #(
	parameter int MAX_DIM = mmu_pkg::MAX_DIM_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	output logic                            full,
	input  wire logic [mmu_pkg::OP_W-1:0]   opcode,
	input  wire logic [mmu_pkg::ROW_W-1:0]  row,
	input  wire logic [mmu_pkg::ROW_W-1:0]  col,
	input  wire logic [mmu_pkg::VAL_W-1:0]  value,
	input  wire logic                       cmd_pop,
	output logic                            cmd_valid,
	output mmu_pkg::cmd_t                   cmd
);

	mmu_pkg::cmd_t                 queue_q [mmu_pkg::CMDQ_DEPTH];
	logic [mmu_pkg::CMDQ_PW-1:0]   wr_ptr_q;
	logic [mmu_pkg::CMDQ_PW-1:0]   rd_ptr_q;
	logic [mmu_pkg::CMDQ_CW-1:0]   count_q;
	logic                          accept;
	logic                          in_range;
	logic                          keep;
	logic                          enq;
	mmu_pkg::cmd_t                 cmd_in;

	// Classify: drop opcode 3 and out-of-range loads
	assign in_range = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);

	always_comb begin
		keep        = 1'b0;
		cmd_in.kind = mmu_pkg::CMD_COMPUTE;
		unique case (opcode)
			mmu_pkg::OP_LOAD_A: begin
				keep        = in_range;
				cmd_in.kind = mmu_pkg::CMD_LOAD_A;
			end
			mmu_pkg::OP_LOAD_B: begin
				keep        = in_range;
				cmd_in.kind = mmu_pkg::CMD_LOAD_B;
			end
			mmu_pkg::OP_COMPUTE: begin
				keep        = 1'b1;
				cmd_in.kind = mmu_pkg::CMD_COMPUTE;
			end
			default: begin
				keep        = 1'b0;
				cmd_in.kind = mmu_pkg::CMD_COMPUTE;
			end
		endcase
		cmd_in.row   = row;
		cmd_in.col   = col;
		cmd_in.value = value;
	end

	assign full      = (count_q == mmu_pkg::CMDQ_CW'(mmu_pkg::CMDQ_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign accept    = push && !full;
	assign enq       = accept && keep;
	assign cmd       = queue_q[rd_ptr_q];

	// Command queue storage
	always_ff @(posedge clk) begin
		if (enq) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + mmu_pkg::CMDQ_PW'(1);
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + mmu_pkg::CMDQ_PW'(1);
			end
			if (enq && !cmd_pop) begin
				count_q <= count_q + mmu_pkg::CMDQ_CW'(1);
			end else if (!enq && cmd_pop) begin
				count_q <= count_q - mmu_pkg::CMDQ_CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/mmu_back.sv
`default_nettype none

module mmu_back #(
	parameter int MAX_DIM = mmu_pkg::MAX_DIM_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire mmu_pkg::dims_t  dims,
	input  wire logic            cmd_valid,
	input  wire mmu_pkg::cmd_t   cmd,
	output logic                 cmd_pop,
	input  wire logic            res_full,
	output logic                 res_push,
	output mmu_pkg::result_t     res
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	logic [mmu_pkg::VAL_W-1:0]         mem_a [DEPTH];
	logic [mmu_pkg::VAL_W-1:0]         mem_b [DEPTH];

	mmu_pkg::seq_state_t               state_q;
	mmu_pkg::seq_state_t               state_d;
	logic [CW-1:0]                     i_q, j_q, k_q;
	logic [CW-1:0]                     i_d, j_d, k_d;
	logic                              adv;
	logic                              dims_good;
	logic                              last_i, last_j, last_k;
	logic                              wr_a, wr_b;
	logic                              issue;
	mmu_pkg::tag_t                     tag_d;
	logic [AW-1:0]                     wr_addr;
	logic [AW-1:0]                     rd_addr_a;
	logic [AW-1:0]                     rd_addr_b;

	logic signed [mmu_pkg::VAL_W-1:0]  rd_a_s1;
	logic signed [mmu_pkg::VAL_W-1:0]  rd_b_s1;
	mmu_pkg::tag_t                     tag_s1;
	logic                              vld_s1;
	logic signed [mmu_pkg::PROD_W-1:0] prod_s2;
	mmu_pkg::tag_t                     tag_s2;
	logic                              vld_s2;
	logic [mmu_pkg::OUT_W-1:0]         acc_q;
	logic [mmu_pkg::OUT_W-1:0]         prod_ext;
	logic [mmu_pkg::OUT_W-1:0]         sum;

	// Whole back end holds while the result queue is full
	assign adv       = !res_full;
	assign dims_good = mmu_pkg::dims_valid(dims, MAX_DIM);

	assign last_k = (mmu_pkg::CFG_W'(k_q) + mmu_pkg::CFG_W'(1)) == dims.cols_a;
	assign last_j = (mmu_pkg::CFG_W'(j_q) + mmu_pkg::CFG_W'(1)) == dims.cols_b;
	assign last_i = (mmu_pkg::CFG_W'(i_q) + mmu_pkg::CFG_W'(1)) == dims.rows_a;

	// Store addresses: row * MAX_DIM + col
	assign wr_addr   = AW'(int'(cmd.row) * MAX_DIM + int'(cmd.col));
	assign rd_addr_a = AW'(int'(i_q) * MAX_DIM + int'(k_q));
	assign rd_addr_b = AW'(int'(k_q) * MAX_DIM + int'(j_q));

	// Sequencer next state: walk i, j, k in row-major order
	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		k_d     = k_q;
		if (adv) begin
			unique case (state_q)
				mmu_pkg::SEQ_IDLE: begin
					if (cmd_valid && cmd.kind == mmu_pkg::CMD_COMPUTE && dims_good) begin
						state_d = mmu_pkg::SEQ_RUN;
						i_d     = '0;
						j_d     = '0;
						k_d     = '0;
					end
				end
				mmu_pkg::SEQ_RUN: begin
					if (!last_k) begin
						k_d = k_q + CW'(1);
					end else begin
						k_d = '0;
						if (!last_j) begin
							j_d = j_q + CW'(1);
						end else begin
							j_d = '0;
							if (!last_i) begin
								i_d = i_q + CW'(1);
							end else begin
								state_d = mmu_pkg::SEQ_IDLE;
							end
						end
					end
				end
			endcase
		end
	end

	// Sequencer outputs: pops, store writes, multiply issue
	always_comb begin
		cmd_pop = 1'b0;
		wr_a    = 1'b0;
		wr_b    = 1'b0;
		issue   = 1'b0;
		tag_d   = '0;
		unique case (state_q)
			mmu_pkg::SEQ_IDLE: begin
				if (adv && cmd_valid) begin
					cmd_pop = 1'b1;
					wr_a    = (cmd.kind == mmu_pkg::CMD_LOAD_A);
					wr_b    = (cmd.kind == mmu_pkg::CMD_LOAD_B);
					if (cmd.kind == mmu_pkg::CMD_COMPUTE && !dims_good) begin
						issue       = 1'b1;
						tag_d.err   = 1'b1;
						tag_d.first = 1'b1;
						tag_d.fin   = 1'b1;
						tag_d.last  = 1'b1;
					end
				end
			end
			mmu_pkg::SEQ_RUN: begin
				if (adv) begin
					issue       = 1'b1;
					tag_d.first = (k_q == '0);
					tag_d.fin   = last_k;
					tag_d.last  = last_k && last_j && last_i;
					tag_d.row   = mmu_pkg::ROW_W'(i_q);
					tag_d.col   = mmu_pkg::ROW_W'(j_q);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmu_pkg::SEQ_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
		end
	end

	// Element stores, registered read
	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[wr_addr] <= cmd.value;
		end
		if (wr_b) begin
			mem_b[wr_addr] <= cmd.value;
		end
		if (adv) begin
			rd_a_s1 <= mem_a[rd_addr_a];
			rd_b_s1 <= mem_b[rd_addr_b];
		end
	end

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
		end
	end

	// Tags and multiply
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1  <= tag_d;
			tag_s2  <= tag_s1;
			prod_s2 <= rd_a_s1 * rd_b_s1;
		end
	end

	// Accumulate; a new inner product starts on its first term
	assign prod_ext = {{(mmu_pkg::OUT_W - mmu_pkg::PROD_W){prod_s2[mmu_pkg::PROD_W-1]}},
		prod_s2};
	assign sum      = tag_s2.first ? prod_ext : acc_q + prod_ext;

	always_ff @(posedge clk) begin
		if (adv && vld_s2) begin
			acc_q <= sum;
		end
	end

	assign res_push      = adv && vld_s2 && tag_s2.fin;
	assign res.row       = tag_s2.row;
	assign res.col       = tag_s2.col;
	assign res.value     = tag_s2.err ? '0 : sum;
	assign res.dim_error = tag_s2.err;
	assign res.last      = tag_s2.last;

endmodule

`default_nettype wire

>>> hdl/mmu_resq.sv
`default_nettype none

module mmu_resq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              res_push,
	input  wire mmu_pkg::result_t  res,
	output logic                   res_full,
	input  wire logic              pop,
	output logic                   empty,
	output mmu_pkg::result_t       head
);

	mmu_pkg::result_t             queue_q [mmu_pkg::RESQ_DEPTH];
	logic [mmu_pkg::RESQ_PW-1:0]  wr_ptr_q;
	logic [mmu_pkg::RESQ_PW-1:0]  rd_ptr_q;
	logic [mmu_pkg::RESQ_CW-1:0]  count_q;
	logic                         deq;

	assign res_full = (count_q == mmu_pkg::RESQ_CW'(mmu_pkg::RESQ_DEPTH));
	assign empty    = (count_q == '0);
	assign deq      = pop && !empty;
	assign head     = queue_q[rd_ptr_q];

	// Result storage
	always_ff @(posedge clk) begin
		if (res_push) begin
			queue_q[wr_ptr_q] <= res;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (res_push) begin
				wr_ptr_q <= wr_ptr_q + mmu_pkg::RESQ_PW'(1);
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + mmu_pkg::RESQ_PW'(1);
			end
			if (res_push && !deq) begin
				count_q <= count_q + mmu_pkg::RESQ_CW'(1);
			end else if (!res_push && deq) begin
				count_q <= count_q - mmu_pkg::RESQ_CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/matrix_multiply_unit.sv
`default_nettype none

// Dense matrix multiplier over two element stores of MAX_DIM x MAX_DIM
// signed Q8.8 entries. Opcode 0 or 1 writes one element of A or B; opcode 2
// checks the dimension registers and then returns every element of A x B in
// row-major order as an exact Q24.16 inner product (last set on the final
// one), or a single result with dim_error set if the dimensions are out of range or disagree.
// Items enter a four-deep command queue and are executed in order by one
// multiply-accumulate sequencer. Loads stream at one item per cycle while
// the output queue has room. A compute issues rows_a * cols_b * cols_a
// multiplies, one per cycle through the single 16x16 multiplier while the
// output queue has room, and an error compute issues a single item. Results
// wait in a four-deep output queue; while that queue is full the sequencer
// holds. Registers are to be written only while the block is idle.
module matrix_multiply_unit #(
	parameter int MAX_DIM = mmu_pkg::MAX_DIM_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Item input
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [mmu_pkg::OP_W-1:0]       opcode,
	input  wire logic [mmu_pkg::ROW_W-1:0]      row,
	input  wire logic [mmu_pkg::ROW_W-1:0]      col,
	input  wire logic signed [mmu_pkg::VAL_W-1:0] value,
	// Result output
	output logic                                empty,
	input  wire logic                           pop,
	output logic [mmu_pkg::ROW_W-1:0]           out_row,
	output logic [mmu_pkg::ROW_W-1:0]           out_col,
	output logic signed [mmu_pkg::OUT_W-1:0]    out_value,
	output logic                                dim_error,
	output logic                                last,
	// Register writes
	input  wire logic                           wr_en,
	input  wire logic [mmu_pkg::REG_IDX_W-1:0]  wr_index,
	input  wire logic [mmu_pkg::CFG_W-1:0]      wr_data
);

	mmu_pkg::dims_t    dims_q;
	mmu_pkg::cmd_t     cmd;
	logic              cmd_valid;
	logic              cmd_pop;
	logic              res_full;
	logic              res_push;
	mmu_pkg::result_t  res;
	mmu_pkg::result_t  head;

	// Dimension registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q.rows_a   <= mmu_pkg::CFG_W'(1);
			dims_q.cols_a   <= mmu_pkg::CFG_W'(1);
			dims_q.rows_b   <= mmu_pkg::CFG_W'(1);
			dims_q.cols_b   <= mmu_pkg::CFG_W'(1);
			dims_q.rows_out <= mmu_pkg::CFG_W'(1);
			dims_q.cols_out <= mmu_pkg::CFG_W'(1);
		end else if (wr_en) begin
			unique case (wr_index)
				mmu_pkg::REG_ROWS_A:   dims_q.rows_a   <= wr_data;
				mmu_pkg::REG_COLS_A:   dims_q.cols_a   <= wr_data;
				mmu_pkg::REG_ROWS_B:   dims_q.rows_b   <= wr_data;
				mmu_pkg::REG_COLS_B:   dims_q.cols_b   <= wr_data;
				mmu_pkg::REG_ROWS_OUT: dims_q.rows_out <= wr_data;
				mmu_pkg::REG_COLS_OUT: dims_q.cols_out <= wr_data;
				default: ;
			endcase
		end
	end

	mmu_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.opcode    (opcode),
		.row       (row),
		.col       (col),
		.value     (value),
		.cmd_pop   (cmd_pop),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	mmu_back #(
		.MAX_DIM(MAX_DIM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dims      (dims_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	mmu_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	assign out_row   = head.row;
	assign out_col   = head.col;
	assign out_value = head.value;
	assign dim_error = head.dim_error;
	assign last      = head.last;

endmodule

`default_nettype wire

>>> test/matrix_multiply_unit_tb.sv
`timescale 1ns / 100ps

// Predicts the product stream of the unit and checks each popped result in order.
class product_tracker;
	localparam int NUM_REGS = 6;
	localparam int SIDE     = mmu_pkg::MAX_DIM_DEF;

	logic [mmu_pkg::CFG_W-1:0]        dims [NUM_REGS];
	logic signed [mmu_pkg::VAL_W-1:0] elem_a [SIDE*SIDE];
	logic signed [mmu_pkg::VAL_W-1:0] elem_b [SIDE*SIDE];
	bit                               loaded_a [SIDE*SIDE];
	bit                               loaded_b [SIDE*SIDE];
	mmu_pkg::result_t                 pending_products [$];
	int                               errors;

	function new();
		for (int i = 0; i < NUM_REGS; i++)
			dims[i] = mmu_pkg::CFG_W'(1);
		for (int i = 0; i < SIDE*SIDE; i++) begin
			elem_a[i] = '0;
			elem_b[i] = '0;
			loaded_a[i] = 0;
			loaded_b[i] = 0;
		end
		errors = 0;
	endfunction

	function void write_reg(logic [mmu_pkg::REG_IDX_W-1:0] idx,
		logic [mmu_pkg::CFG_W-1:0] data);
		// indexes past the list are dropped by the unit
		if (int'(idx) < NUM_REGS)
			dims[idx] = data;
	endfunction

	function bit side_ok(logic [mmu_pkg::CFG_W-1:0] d);
		return int'(d) >= 1 && int'(d) <= SIDE;
	endfunction

	function bit shape_ok();
		return side_ok(dims[mmu_pkg::REG_ROWS_A]) && side_ok(dims[mmu_pkg::REG_COLS_A]) &&
			side_ok(dims[mmu_pkg::REG_ROWS_B]) && side_ok(dims[mmu_pkg::REG_COLS_B]) &&
			side_ok(dims[mmu_pkg::REG_ROWS_OUT]) &&
			side_ok(dims[mmu_pkg::REG_COLS_OUT]) &&
			dims[mmu_pkg::REG_COLS_A] == dims[mmu_pkg::REG_ROWS_B] &&
			dims[mmu_pkg::REG_ROWS_A] == dims[mmu_pkg::REG_ROWS_OUT] &&
			dims[mmu_pkg::REG_COLS_B] == dims[mmu_pkg::REG_COLS_OUT];
	endfunction

	// True when a compute now would only read loaded entries
	function bit operands_ready();
		if (!shape_ok())
			return 1;
		for (int i = 0; i < int'(dims[mmu_pkg::REG_ROWS_A]); i++)
			for (int k = 0; k < int'(dims[mmu_pkg::REG_COLS_A]); k++)
				if (!loaded_a[i*SIDE + k])
					return 0;
		for (int k = 0; k < int'(dims[mmu_pkg::REG_COLS_A]); k++)
			for (int j = 0; j < int'(dims[mmu_pkg::REG_COLS_B]); j++)
				if (!loaded_b[k*SIDE + j])
					return 0;
		return 1;
	endfunction

	// Accepted input item: update stores or queue the products it causes
	function void note_item(logic [mmu_pkg::OP_W-1:0] op, logic [mmu_pkg::ROW_W-1:0] r,
		logic [mmu_pkg::ROW_W-1:0] c, logic signed [mmu_pkg::VAL_W-1:0] v);
		int               addr;
		longint           sum;
		mmu_pkg::result_t res;
		addr = int'(r) * SIDE + int'(c);
		case (op)
			mmu_pkg::OP_LOAD_A: begin
				elem_a[addr] = v;
				loaded_a[addr] = 1;
			end
			mmu_pkg::OP_LOAD_B: begin
				elem_b[addr] = v;
				loaded_b[addr] = 1;
			end
			mmu_pkg::OP_COMPUTE: begin
				if (!shape_ok()) begin
					res = '0;
					res.dim_error = 1'b1;
					res.last = 1'b1;
					pending_products.push_back(res);
				end else begin
					for (int i = 0; i < int'(dims[mmu_pkg::REG_ROWS_A]); i++)
						for (int j = 0; j < int'(dims[mmu_pkg::REG_COLS_B]); j++) begin
							sum = 0;
							for (int k = 0; k < int'(dims[mmu_pkg::REG_COLS_A]); k++)
								sum += longint'(elem_a[i*SIDE + k]) *
									longint'(elem_b[k*SIDE + j]);
							res.row = mmu_pkg::ROW_W'(i);
							res.col = mmu_pkg::ROW_W'(j);
							res.value = sum[mmu_pkg::OUT_W-1:0];
							res.dim_error = 1'b0;
							res.last = (i == int'(dims[mmu_pkg::REG_ROWS_A]) - 1) &&
								(j == int'(dims[mmu_pkg::REG_COLS_B]) - 1);
							pending_products.push_back(res);
						end
				end
			end
			default: ;
		endcase
	endfunction

	// Popped result item: compare with the oldest predicted one
	function void check_result(logic [mmu_pkg::ROW_W-1:0] r, logic [mmu_pkg::ROW_W-1:0] c,
		logic [mmu_pkg::OUT_W-1:0] v, logic e, logic l);
		mmu_pkg::result_t want;
		if (pending_products.size() == 0) begin
			$display("%0t: unexpected result row %0d col %0d value %0d err %b last %b",
				$time, r, c, $signed(v), e, l);
			errors++;
			return;
		end
		want = pending_products.pop_front();
		if (want.row !== r) begin
			$display("%0t: out_row expected %0d actual %0d", $time, want.row, r);
			errors++;
		end
		if (want.col !== c) begin
			$display("%0t: out_col expected %0d actual %0d", $time, want.col, c);
			errors++;
		end
		if (want.value !== v) begin
			$display("%0t: out_value expected %0d actual %0d", $time,
				$signed(want.value), $signed(v));
			errors++;
		end
		if (want.dim_error !== e) begin
			$display("%0t: dim_error expected %b actual %b", $time, want.dim_error, e);
			errors++;
		end
		if (want.last !== l) begin
			$display("%0t: last expected %b actual %b", $time, want.last, l);
			errors++;
		end
	endfunction
endclass

module matrix_multiply_unit_tb;
	localparam int NUM_REGS     = 6;
	localparam int SIDE         = mmu_pkg::MAX_DIM_DEF;
	localparam int RANDOM_ITEMS = 80;
	localparam int SETTLE       = 24;
	localparam int LIMIT_CYCLES = 2000000;

	// opcode the unit ignores; register indexes past the list
	localparam logic [mmu_pkg::OP_W-1:0]      OP_NOP        = 2'd3;
	localparam logic [mmu_pkg::REG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [mmu_pkg::REG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

	logic                              clk;
	logic                              arst_n;
	logic                              push;
	logic                              full;
	logic [mmu_pkg::OP_W-1:0]          opcode;
	logic [mmu_pkg::ROW_W-1:0]         row;
	logic [mmu_pkg::ROW_W-1:0]         col;
	logic signed [mmu_pkg::VAL_W-1:0]  value;
	logic                              empty;
	logic                              pop;
	logic [mmu_pkg::ROW_W-1:0]         out_row;
	logic [mmu_pkg::ROW_W-1:0]         out_col;
	logic signed [mmu_pkg::OUT_W-1:0]  out_value;
	logic                              dim_error;
	logic                              last;
	logic                              wr_en;
	logic [mmu_pkg::REG_IDX_W-1:0]     wr_index;
	logic [mmu_pkg::CFG_W-1:0]         wr_data;

	product_tracker tracker;
	int  cycle_count;
	bit  send_burst;
	bit  pop_burst;

	matrix_multiply_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.opcode    (opcode),
		.row       (row),
		.col       (col),
		.value     (value),
		.empty     (empty),
		.pop       (pop),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_value (out_value),
		.dim_error (dim_error),
		.last      (last),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	always #2 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	// check every popped item
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			tracker.check_result(out_row, out_col, out_value, dim_error, last);
	end

	// mostly short gaps, a few long ones, none in burst stretches
	function automatic int pick_gap(bit burst);
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic signed [mmu_pkg::VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'sh8000;
		if (r == 1)
			return 16'sh7fff;
		return mmu_pkg::VAL_W'($urandom);
	endfunction

	// small sides mostly, the largest now and then
	function automatic int pick_side();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return SIDE;
		if (r < 3)
			return $urandom_range(4, SIDE - 1);
		return $urandom_range(1, 3);
	endfunction

	// result side: random stalls on pop
	initial begin
		@(posedge arst_n);
		forever begin
			int gap;
			if ($urandom_range(0, 15) == 0)
				pop_burst = ~pop_burst;
			gap = pick_gap(pop_burst);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	task automatic send_item(logic [mmu_pkg::OP_W-1:0] op, logic [mmu_pkg::ROW_W-1:0] r,
		logic [mmu_pkg::ROW_W-1:0] c, logic signed [mmu_pkg::VAL_W-1:0] v);
		int gap;
		gap = pick_gap(send_burst);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		opcode <= op;
		row <= r;
		col <= c;
		value <= v;
		do @(posedge clk); while (full);
		tracker.note_item(op, r, c, v);
	endtask

	// stop sending and wait until every predicted result has been popped
	task automatic drain();
		push <= 1'b0;
		while (tracker.pending_products.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [mmu_pkg::REG_IDX_W-1:0] idx,
		logic [mmu_pkg::CFG_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		tracker.write_reg(idx, data);
	endtask

	// all registers, only once the unit is idle; sometimes a write past the list
	task automatic set_dims(input int d [NUM_REGS], input bit spare);
		drain();
		write_reg(mmu_pkg::REG_ROWS_A, mmu_pkg::CFG_W'(d[mmu_pkg::REG_ROWS_A]));
		write_reg(mmu_pkg::REG_COLS_A, mmu_pkg::CFG_W'(d[mmu_pkg::REG_COLS_A]));
		if (spare)
			write_reg(REG_UNUSED_LO, mmu_pkg::CFG_W'($urandom));
		write_reg(mmu_pkg::REG_ROWS_B, mmu_pkg::CFG_W'(d[mmu_pkg::REG_ROWS_B]));
		write_reg(mmu_pkg::REG_COLS_B, mmu_pkg::CFG_W'(d[mmu_pkg::REG_COLS_B]));
		write_reg(mmu_pkg::REG_ROWS_OUT, mmu_pkg::CFG_W'(d[mmu_pkg::REG_ROWS_OUT]));
		write_reg(mmu_pkg::REG_COLS_OUT, mmu_pkg::CFG_W'(d[mmu_pkg::REG_COLS_OUT]));
		if (spare)
			write_reg(REG_UNUSED_HI, mmu_pkg::CFG_W'($urandom));
		wr_en <= 1'b0;
	endtask

	// load missing operand entries, refresh some of the others
	task automatic load_operands(output int count);
		int ra, ca, cb;
		ra = int'(tracker.dims[mmu_pkg::REG_ROWS_A]);
		ca = int'(tracker.dims[mmu_pkg::REG_COLS_A]);
		cb = int'(tracker.dims[mmu_pkg::REG_COLS_B]);
		count = 0;
		if (!tracker.shape_ok())
			return;
		for (int i = 0; i < ra; i++)
			for (int k = 0; k < ca; k++)
				if (!tracker.loaded_a[i*SIDE + k] || $urandom_range(0, 3) == 0) begin
					send_item(mmu_pkg::OP_LOAD_A, mmu_pkg::ROW_W'(i), mmu_pkg::ROW_W'(k),
						pick_value());
					count++;
				end
		for (int k = 0; k < ca; k++)
			for (int j = 0; j < cb; j++)
				if (!tracker.loaded_b[k*SIDE + j] || $urandom_range(0, 3) == 0) begin
					send_item(mmu_pkg::OP_LOAD_B, mmu_pkg::ROW_W'(k), mmu_pkg::ROW_W'(j),
						pick_value());
					count++;
				end
	endtask

	initial begin
		int  d [NUM_REGS];
		int  sent;
		int  n;
		int  roll;
		bit  paused;

		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		opcode = mmu_pkg::OP_LOAD_A;
		row = '0;
		col = '0;
		value = '0;
		pop = 1'b0;
		wr_en = 1'b0;
		wr_index = mmu_pkg::REG_ROWS_A;
		wr_data = '0;
		cycle_count = 0;
		send_burst = 0;
		pop_burst = 0;
		tracker = new();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 1x1 at reset dims: value extremes, ignored opcode
		send_item(mmu_pkg::OP_LOAD_A, 3'd0, 3'd0, 16'sh8000);
		send_item(mmu_pkg::OP_LOAD_B, 3'd0, 3'd0, 16'sh8000);
		send_item(mmu_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'sh0000);
		send_item(mmu_pkg::OP_LOAD_A, 3'd0, 3'd0, 16'sh7fff);
		send_item(mmu_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'sh0000);
		send_item(mmu_pkg::OP_LOAD_B, 3'd0, 3'd0, 16'sh7fff);
		send_item(mmu_pkg::OP_COMPUTE, 3'd7, 3'd7, 16'shffff);
		send_item(OP_NOP, 3'd7, 3'd7, 16'sh7fff);
		send_item(mmu_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'sh0000);

		// 8x1 times 1x8: largest output, all rows and columns
		d = '{8, 1, 1, 8, 8, 8};
		set_dims(d, 1);
		load_operands(n);
		send_item(mmu_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'sh0000);

		// dimension errors: zero side, side above the limit, mismatch
		d = '{0, 1, 1, 1, 1, 1};
		set_dims(d, 0);
		send_item(mmu_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'sh0000);
		d = '{15, 1, 1, 1, 15, 1};
		set_dims(d, 0);
		send_item(mmu_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'sh0000);
		d = '{2, 3, 2, 2, 2, 2};
		set_dims(d, 0);
		send_item(mmu_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'sh0000);

		// random part
		sent = 0;
		paused = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				send_burst = ~send_burst;
			roll = $urandom_range(0, 99);
			if (roll < 12) begin
				// new shape: mostly consistent, else random or one register off
				d[mmu_pkg::REG_ROWS_A] = pick_side();
				d[mmu_pkg::REG_COLS_A] = pick_side();
				d[mmu_pkg::REG_COLS_B] = pick_side();
				d[mmu_pkg::REG_ROWS_B] = d[mmu_pkg::REG_COLS_A];
				d[mmu_pkg::REG_ROWS_OUT] = d[mmu_pkg::REG_ROWS_A];
				d[mmu_pkg::REG_COLS_OUT] = d[mmu_pkg::REG_COLS_B];
				n = $urandom_range(0, 7);
				if (n == 0) begin
					for (int i = 0; i < NUM_REGS; i++)
						d[i] = $urandom_range(0, 15);
				end else if (n == 1) begin
					d[$urandom_range(0, NUM_REGS - 1)] = $urandom_range(0, 15);
				end
				set_dims(d, $urandom_range(0, 2) == 0);
			end else if (roll < 72) begin
				load_operands(n);
				send_item(mmu_pkg::OP_COMPUTE, mmu_pkg::ROW_W'($urandom),
					mmu_pkg::ROW_W'($urandom), mmu_pkg::VAL_W'($urandom));
				sent += n + 1;
			end else if (roll < 84) begin
				repeat ($urandom_range(1, 4)) begin
					send_item($urandom_range(0, 1) ? mmu_pkg::OP_LOAD_B : mmu_pkg::OP_LOAD_A,
						mmu_pkg::ROW_W'($urandom), mmu_pkg::ROW_W'($urandom), pick_value());
					sent++;
				end
			end else if (roll < 90) begin
				send_item(OP_NOP, mmu_pkg::ROW_W'($urandom), mmu_pkg::ROW_W'($urandom),
					mmu_pkg::VAL_W'($urandom));
				sent++;
			end else if (tracker.operands_ready()) begin
				// compute again on whatever the stores hold
				send_item(mmu_pkg::OP_COMPUTE, mmu_pkg::ROW_W'($urandom),
					mmu_pkg::ROW_W'($urandom), mmu_pkg::VAL_W'($urandom));
				sent++;
			end else begin
				send_item(mmu_pkg::OP_LOAD_A, mmu_pkg::ROW_W'($urandom),
					mmu_pkg::ROW_W'($urandom), pick_value());
				sent++;
			end
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				drain();
				paused = 1;
			end
		end

		drain();
		if (tracker.errors == 0 && tracker.pending_products.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

>>> sim.f
hdl/mmu_pkg.sv
hdl/mmu_front.sv
hdl/mmu_back.sv
hdl/mmu_resq.sv
hdl/matrix_multiply_unit.sv
test/matrix_multiply_unit_tb.sv
